>>> rtl/core/crc16fr_pkg.sv
// ----------------------------------------------------------------------------
// crc16fr_pkg
// Shared types, codes and the CRC-16/MODBUS byte update for the frame receiver.
// ----------------------------------------------------------------------------
package crc16fr_pkg;

	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

	// configuration register indexes
	localparam logic REG_SYNC_FIRST  = 1'b0;
	localparam logic REG_SYNC_SECOND = 1'b1;

	typedef enum logic [2:0] {
		ST_BUSY   = 3'd0,
		ST_DATA   = 3'd1,
		ST_GOOD   = 3'd2,
		ST_LENERR = 3'd3,
		ST_CRCERR = 3'd4
	} status_t;

	typedef enum logic [7:0] {
		PH_SYNC0   = 8'b0000_0001,
		PH_SYNC1   = 8'b0000_0010,
		PH_CMD     = 8'b0000_0100,
		PH_LEN0    = 8'b0000_1000,
		PH_LEN1    = 8'b0001_0000,
		PH_PAYLOAD = 8'b0010_0000,
		PH_CRC0    = 8'b0100_0000,
		PH_CRC1    = 8'b1000_0000
	} phase_t;

	// reflected crc, one byte folded in over eight bit steps
	function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
			input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/core/crc16_frame_receiver.sv
// ----------------------------------------------------------------------------
// crc16_frame_receiver
// Byte-serial frame parser: two sync bytes, command, little-endian length,
// payload and a little-endian CRC-16/MODBUS over command, length and payload.
// Every accepted byte gives exactly one result: in progress, a tentative
// payload byte with its index, frame good (with command and length), length
// too long, or crc mismatch. Payload bytes must be buffered by the consumer
// and committed only on frame good. One byte is taken per clock cycle when
// the result side does not stall; results pass an input register and a
// result register, and the eight-step crc update is done combinationally
// between them. Sync byte values are written through the cfg port (index 0
// first sync byte, index 1 second), and the user must write them only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module crc16_frame_receiver #(
	parameter int MAX_PAYLOAD = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	// result output
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  status,
	output logic [7:0]  command,
	output logic [10:0] frame_length,
	output logic [7:0]  data_byte,
	output logic [9:0]  byte_index,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int CW = $clog2(MAX_PAYLOAD + 1);

	logic [7:0]  sync_first_q, sync_second_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;

	crc16fr_pkg::phase_t phase_q, phase_n;
	logic [7:0]  command_q, command_n;
	logic [15:0] length_q, length_n;
	logic [CW-1:0] count_q, count_n;
	logic [15:0] crc_q, crc_n;
	logic [7:0]  crc_lo_q, crc_lo_n;

	logic        res_valid_q;
	crc16fr_pkg::status_t status_q, status_n;
	logic [7:0]  command_out_q, command_out_n;
	logic [10:0] flen_q, flen_n;
	logic [7:0]  dbyte_q, dbyte_n;
	logic [9:0]  didx_q, didx_n;

	logic        advance;
	logic        fire;
	logic [15:0] crc_step;
	logic [15:0] length_full;
	logic [CW:0] count_inc;

	// the item in s1 moves on when the result register is free or being emptied
	assign advance  = !res_valid_q || !res_stall;
	assign fire     = valid_s1 && advance;
	assign rx_stall = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	assign crc_step    = crc16fr_pkg::crc_update(crc_q, byte_s1);
	assign length_full = {byte_s1, length_q[7:0]};
	assign count_inc   = {1'b0, count_q} + {{CW{1'b0}}, 1'b1};

	always_comb begin
		phase_n       = phase_q;
		command_n     = command_q;
		length_n      = length_q;
		count_n       = count_q;
		crc_n         = crc_q;
		crc_lo_n      = crc_lo_q;
		status_n      = crc16fr_pkg::ST_BUSY;
		command_out_n = '0;
		flen_n        = '0;
		dbyte_n       = '0;
		didx_n        = '0;
		case (phase_q)
			crc16fr_pkg::PH_SYNC0: begin
				if (byte_s1 == sync_first_q) begin
					phase_n = crc16fr_pkg::PH_SYNC1;
				end
			end
			crc16fr_pkg::PH_SYNC1: begin
				// second sync tested first so equal sync values still start a frame
				if (byte_s1 == sync_second_q) begin
					crc_n   = crc16fr_pkg::CRC_INIT;
					phase_n = crc16fr_pkg::PH_CMD;
				end else if (byte_s1 == sync_first_q) begin
					phase_n = crc16fr_pkg::PH_SYNC1;
				end else begin
					phase_n = crc16fr_pkg::PH_SYNC0;
				end
			end
			crc16fr_pkg::PH_CMD: begin
				command_n = byte_s1;
				crc_n     = crc_step;
				phase_n   = crc16fr_pkg::PH_LEN0;
			end
			crc16fr_pkg::PH_LEN0: begin
				length_n = {8'h00, byte_s1};
				crc_n    = crc_step;
				phase_n  = crc16fr_pkg::PH_LEN1;
			end
			crc16fr_pkg::PH_LEN1: begin
				if (length_full > 16'(MAX_PAYLOAD)) begin
					phase_n   = crc16fr_pkg::PH_SYNC0;
					command_n = '0;
					length_n  = '0;
					count_n   = '0;
					crc_n     = crc16fr_pkg::CRC_INIT;
					crc_lo_n  = '0;
					status_n  = crc16fr_pkg::ST_LENERR;
				end else begin
					length_n = length_full;
					crc_n    = crc_step;
					count_n  = '0;
					phase_n  = (length_full == 16'd0) ? crc16fr_pkg::PH_CRC0
						: crc16fr_pkg::PH_PAYLOAD;
				end
			end
			crc16fr_pkg::PH_PAYLOAD: begin
				crc_n    = crc_step;
				status_n = crc16fr_pkg::ST_DATA;
				dbyte_n  = byte_s1;
				didx_n   = 10'(count_q);
				count_n  = count_inc[CW-1:0];
				// stored length never exceeds MAX_PAYLOAD, so it fits in CW+1 bits
				if (count_inc >= (CW+1)'(length_q)) begin
					phase_n = crc16fr_pkg::PH_CRC0;
				end
			end
			crc16fr_pkg::PH_CRC0: begin
				crc_lo_n = byte_s1;
				phase_n  = crc16fr_pkg::PH_CRC1;
			end
			crc16fr_pkg::PH_CRC1: begin
				if ({byte_s1, crc_lo_q} == crc_q) begin
					status_n      = crc16fr_pkg::ST_GOOD;
					command_out_n = command_q;
					flen_n        = 11'(length_q);
				end else begin
					status_n = crc16fr_pkg::ST_CRCERR;
				end
				phase_n   = crc16fr_pkg::PH_SYNC0;
				command_n = '0;
				length_n  = '0;
				count_n   = '0;
				crc_n     = crc16fr_pkg::CRC_INIT;
				crc_lo_n  = '0;
			end
			default: begin
				phase_n   = crc16fr_pkg::PH_SYNC0;
				command_n = '0;
				length_n  = '0;
				count_n   = '0;
				crc_n     = crc16fr_pkg::CRC_INIT;
				crc_lo_n  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= crc16fr_pkg::SYNC_FIRST_RST;
			sync_second_q <= crc16fr_pkg::SYNC_SECOND_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == crc16fr_pkg::REG_SYNC_FIRST) begin
				sync_first_q <= cfg_data;
			end else if (cfg_index == crc16fr_pkg::REG_SYNC_SECOND) begin
				sync_second_q <= cfg_data;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_valid && !rx_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= crc16fr_pkg::PH_SYNC0;
			command_q <= '0;
			length_q  <= '0;
			count_q   <= '0;
			crc_q     <= crc16fr_pkg::CRC_INIT;
			crc_lo_q  <= '0;
		end else if (fire) begin
			phase_q   <= phase_n;
			command_q <= command_n;
			length_q  <= length_n;
			count_q   <= count_n;
			crc_q     <= crc_n;
			crc_lo_q  <= crc_lo_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q      <= status_n;
			command_out_q <= command_out_n;
			flen_q        <= flen_n;
			dbyte_q       <= dbyte_n;
			didx_q        <= didx_n;
		end
	end

	assign res_valid    = res_valid_q;
	assign status       = status_q;
	assign command      = command_out_q;
	assign frame_length = flen_q;
	assign data_byte    = dbyte_q;
	assign byte_index   = didx_q;

`ifndef SYNTH
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_count_below_length: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == crc16fr_pkg::PH_PAYLOAD) |-> ((CW+1)'(length_q) > {1'b0, count_q}))
		else $error("payload count reached length while still in payload");

	a_frame_end_rehunt: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && phase_q == crc16fr_pkg::PH_CRC1) |=>
		(phase_q == crc16fr_pkg::PH_SYNC0 && crc_q == crc16fr_pkg::CRC_INIT))
		else $error("parser did not return to hunt after frame end");

	a_data_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status != crc16fr_pkg::ST_DATA) |->
		(data_byte == 8'h00 && byte_index == 10'd0))
		else $error("payload fields set on a non-payload result");

	a_frame_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status != crc16fr_pkg::ST_GOOD) |->
		(command == 8'h00 && frame_length == 11'd0))
		else $error("frame fields set on a result other than frame good");
`endif

endmodule
